/* design/fbc_pkg.sv */
// Shared types and constants for the frame store raster block.
// No dependencies; every other design file depends on this package.
`default_nettype none

package fbc_pkg;

  localparam int OP_W    = 3;
  localparam int COORD_W = 8;
  localparam int CHAN_W  = 8;
  localparam int PIX_W   = 3 * CHAN_W;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  localparam logic [COORD_W-1:0] FRAME_W_RESET = 8'd100;
  localparam logic [COORD_W-1:0] FRAME_H_RESET = 8'd100;

  // Register index, taken from paddr[2]
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_SET  = 3'd0,
    OP_READ = 3'd1,
    OP_FILL = 3'd2,
    OP_BOX  = 3'd3,
    OP_DISC = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_READ,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic clear_en;
    logic latch;
    logic scan_en;
    logic read_en;
    logic load_result;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic scan_last;
    logic empty;
  } dp_status_t;

endpackage

`default_nettype wire

/* design/fbc_cmd_if.sv */
// Command channel: valid/ready handshake with one command per beat.
// Depends on fbc_pkg for field widths.
`default_nettype none

interface fbc_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [fbc_pkg::OP_W-1:0]    op;
  logic [fbc_pkg::COORD_W-1:0] x_start;
  logic [fbc_pkg::COORD_W-1:0] y_start;
  logic [fbc_pkg::COORD_W-1:0] x_end;
  logic [fbc_pkg::COORD_W-1:0] y_end;
  logic [fbc_pkg::COORD_W-1:0] radius;
  logic [fbc_pkg::CHAN_W-1:0]  red;
  logic [fbc_pkg::CHAN_W-1:0]  green;
  logic [fbc_pkg::CHAN_W-1:0]  blue;

  modport source (
    output valid, op, x_start, y_start, x_end, y_end, radius, red, green, blue,
    input  ready
  );

  modport sink (
    input  valid, op, x_start, y_start, x_end, y_end, radius, red, green, blue,
    output ready
  );
endinterface

`default_nettype wire

/* design/fbc_rsp_if.sv */
// Response channel: valid/ready handshake with one result per beat.
// Depends on fbc_pkg for field widths.
`default_nettype none

interface fbc_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [fbc_pkg::CHAN_W-1:0] read_red;
  logic [fbc_pkg::CHAN_W-1:0] read_green;
  logic [fbc_pkg::CHAN_W-1:0] read_blue;
  logic                       read_valid;

  modport source (
    output valid, read_red, read_green, read_blue, read_valid,
    input  ready
  );

  modport sink (
    input  valid, read_red, read_green, read_blue, read_valid,
    output ready
  );
endinterface

`default_nettype wire

/* design/fbc_cfg.sv */
// APB-style register file: frame_width and frame_height.
// Depends on fbc_pkg.
`default_nettype none

module fbc_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [fbc_pkg::APB_AW-1:0]  paddr,
  input  wire logic [fbc_pkg::APB_DW-1:0]  pwdata,
  output logic      [fbc_pkg::APB_DW-1:0]  prdata,
  output logic                             pready,
  output logic      [fbc_pkg::COORD_W-1:0] frame_width,
  output logic      [fbc_pkg::COORD_W-1:0] frame_height
);
  import fbc_pkg::*;

  logic wr_en;
  logic reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_W_RESET;
      frame_height <= FRAME_H_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_FRAME_WIDTH:  frame_width  <= pwdata[COORD_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FRAME_WIDTH:  prdata = {{(APB_DW-COORD_W){1'b0}}, frame_width};
      REG_FRAME_HEIGHT: prdata = {{(APB_DW-COORD_W){1'b0}}, frame_height};
      default:          prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* design/fbc_ctrl.sv */
// Controller FSM: clearing pass, command dispatch, scan, read and result hand-off.
// Depends on fbc_pkg; drives fbc_dp through dp_cmd_t and reads dp_status_t.
`default_nettype none

module fbc_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cmd_valid,
  output logic                          cmd_ready,
  input  wire logic [fbc_pkg::OP_W-1:0] cmd_op,
  output logic                          rsp_valid,
  input  wire logic                     rsp_ready,
  output fbc_pkg::dp_cmd_t              dpc,
  input  wire fbc_pkg::dp_status_t      dps
);
  import fbc_pkg::*;

  state_t state, state_next;
  logic   out_valid;
  logic   accept;
  logic   slot_free;
  op_t    op_code;

  assign op_code   = op_t'(cmd_op);
  assign accept    = cmd_valid && (state == S_IDLE);
  assign slot_free = !out_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (dps.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (cmd_valid) begin
          unique case (op_code) inside
            OP_READ: state_next = S_READ;
            OP_SET, OP_FILL, OP_BOX, OP_DISC:
              state_next = dps.empty ? S_FINISH : S_SCAN;
            default: state_next = S_FINISH;
          endcase
        end
      end
      S_SCAN: begin
        if (dps.scan_last) state_next = S_DRAIN;
      end
      S_DRAIN:  state_next = S_FINISH;
      S_READ:   state_next = S_FINISH;
      S_FINISH: begin
        if (slot_free) state_next = S_IDLE;
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready       = (state == S_IDLE);
    dpc.clear_en    = (state == S_CLEAR);
    dpc.latch       = accept;
    dpc.scan_en     = (state == S_SCAN);
    dpc.read_en     = (state == S_READ);
    dpc.load_result = (state == S_FINISH) && slot_free;
  end

  // Output slot: fill on load, drop when the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (dpc.load_result) begin
      out_valid <= 1'b1;
    end else if (rsp_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign rsp_valid = out_valid;

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    dpc.load_result |-> (!out_valid || rsp_ready))
    else $error("result loaded over a pending beat");

  a_no_rsp_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !out_valid)
    else $error("result present during clearing pass");

  a_rise_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_FINISH))
    else $error("result appeared outside finish");
`endif

endmodule

`default_nettype wire

/* design/fbc_dp.sv */
// Datapath: frame store, clearing counter, scan counters, two-stage disc
// test pipeline and the result register. Depends on fbc_pkg.
`default_nettype none

module fbc_dp #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire fbc_pkg::dp_cmd_t            dpc,
  output fbc_pkg::dp_status_t              dps,
  input  wire logic [fbc_pkg::COORD_W-1:0] frame_width,
  input  wire logic [fbc_pkg::COORD_W-1:0] frame_height,
  input  wire logic [fbc_pkg::OP_W-1:0]    op,
  input  wire logic [fbc_pkg::COORD_W-1:0] x_start,
  input  wire logic [fbc_pkg::COORD_W-1:0] y_start,
  input  wire logic [fbc_pkg::COORD_W-1:0] x_end,
  input  wire logic [fbc_pkg::COORD_W-1:0] y_end,
  input  wire logic [fbc_pkg::COORD_W-1:0] radius,
  input  wire logic [fbc_pkg::CHAN_W-1:0]  red,
  input  wire logic [fbc_pkg::CHAN_W-1:0]  green,
  input  wire logic [fbc_pkg::CHAN_W-1:0]  blue,
  output logic      [fbc_pkg::CHAN_W-1:0]  read_red,
  output logic      [fbc_pkg::CHAN_W-1:0]  read_green,
  output logic      [fbc_pkg::CHAN_W-1:0]  read_blue,
  output logic                             read_valid
);
  import fbc_pkg::*;

  localparam int DEPTH    = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CLIP_W   = (MAX_WIDTH  > 255) ? 255 : MAX_WIDTH;
  localparam int CLIP_H   = (MAX_HEIGHT > 255) ? 255 : MAX_HEIGHT;
  localparam int SQ_W     = 2 * COORD_W + 1;
  localparam int R2_W     = 2 * COORD_W;

  logic [PIX_W-1:0]   mem [DEPTH];

  // Active area
  logic [COORD_W-1:0] act_w, act_h;
  // Window decode at accept
  op_t                op_code;
  logic [COORD_W-1:0] win_x0, win_y0, win_x1, win_y1, win_x1c, win_y1c;
  logic               win_empty;
  logic               rd_inb;

  // Latched command
  logic [COORD_W-1:0] x0_r, x1c_r, y1c_r, cx_r, cy_r;
  logic [R2_W-1:0]    r2_r;
  logic [PIX_W-1:0]   colour_r;
  logic               is_disc_r, is_read_r, inb_r;
  logic [AW-1:0]      raddr_r;

  // Scan counters
  logic [COORD_W-1:0] sx, sy;

  // Stage 1
  logic signed [COORD_W:0]     dx, dy;
  logic signed [2*COORD_W+1:0] dx_prod, dy_prod;
  logic                        p1_valid;
  logic [COORD_W-1:0]          p1_x, p1_y;
  logic [SQ_W-1:0]             p1_dx2, p1_dy2;

  // Stage 2 / write port
  logic [SQ_W:0]      dist2;
  logic               hit;
  logic [AW-1:0]      clr_cnt;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [PIX_W-1:0]   wdata;
  logic [PIX_W-1:0]   rd_data;

  assign act_w = (frame_width  > COORD_W'(CLIP_W)) ? COORD_W'(CLIP_W) : frame_width;
  assign act_h = (frame_height > COORD_W'(CLIP_H)) ? COORD_W'(CLIP_H) : frame_height;

  assign op_code = op_t'(op);

  always_comb begin
    unique case (op_code)
      OP_SET: begin
        win_x0 = x_start; win_y0 = y_start; win_x1 = x_start; win_y1 = y_start;
      end
      OP_BOX: begin
        win_x0 = x_start; win_y0 = y_start; win_x1 = x_end;   win_y1 = y_end;
      end
      default: begin
        // Whole frame and disc scan the full active area
        win_x0 = '0; win_y0 = '0; win_x1 = '1; win_y1 = '1;
      end
    endcase
  end

  assign win_x1c   = (win_x1 >= act_w) ? act_w - 1'b1 : win_x1;
  assign win_y1c   = (win_y1 >= act_h) ? act_h - 1'b1 : win_y1;
  assign win_empty = (act_w == '0) || (act_h == '0) ||
                     (win_x0 > win_x1c) || (win_y0 > win_y1c);
  assign rd_inb    = (x_start < act_w) && (y_start < act_h);

  always_ff @(posedge clk) begin
    if (dpc.latch) begin
      x0_r      <= win_x0;
      x1c_r     <= win_x1c;
      y1c_r     <= win_y1c;
      cx_r      <= x_start;
      cy_r      <= y_start;
      r2_r      <= R2_W'(radius) * R2_W'(radius);
      colour_r  <= {red, green, blue};
      is_disc_r <= (op_code == OP_DISC);
      is_read_r <= (op_code == OP_READ);
      inb_r     <= rd_inb;
      raddr_r   <= AW'(AW'(y_start) * AW'(MAX_WIDTH) + AW'(x_start));
    end
  end

  // Scan walk: row by row over the clipped window
  always_ff @(posedge clk) begin
    if (dpc.latch) begin
      sx <= win_x0;
      sy <= win_y0;
    end else if (dpc.scan_en) begin
      if (sx == x1c_r) begin
        sx <= x0_r;
        sy <= sy + 1'b1;
      end else begin
        sx <= sx + 1'b1;
      end
    end
  end

  assign dx      = $signed({1'b0, sx}) - $signed({1'b0, cx_r});
  assign dy      = $signed({1'b0, sy}) - $signed({1'b0, cy_r});
  assign dx_prod = dx * dx;
  assign dy_prod = dy * dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= dpc.scan_en;
    end
  end

  always_ff @(posedge clk) begin
    if (dpc.scan_en) begin
      p1_x   <= sx;
      p1_y   <= sy;
      p1_dx2 <= dx_prod[SQ_W-1:0];
      p1_dy2 <= dy_prod[SQ_W-1:0];
    end
  end

  assign dist2 = {1'b0, p1_dx2} + {1'b0, p1_dy2};
  assign hit   = !is_disc_r || (dist2 <= (SQ_W+1)'(r2_r));

  // Clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (dpc.clear_en) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_comb begin
    if (dpc.clear_en) begin
      we    = 1'b1;
      waddr = clr_cnt;
      wdata = '0;
    end else begin
      we    = p1_valid && hit;
      waddr = AW'(AW'(p1_y) * AW'(MAX_WIDTH) + AW'(p1_x));
      wdata = colour_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (dpc.read_en) begin
      rd_data <= mem[raddr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_red   <= '0;
      read_green <= '0;
      read_blue  <= '0;
      read_valid <= 1'b0;
    end else if (dpc.load_result) begin
      if (is_read_r && inb_r) begin
        {read_red, read_green, read_blue} <= rd_data;
      end else begin
        {read_red, read_green, read_blue} <= '0;
      end
      read_valid <= is_read_r;
    end
  end

  assign dps.clear_done = (clr_cnt == AW'(DEPTH - 1));
  assign dps.scan_last  = (sx == x1c_r) && (sy == y1c_r);
  assign dps.empty      = win_empty;

`ifndef SYNTHESIS
  a_clear_excl: assert property (@(posedge clk) disable iff (rst)
    !(dpc.clear_en && p1_valid))
    else $error("pixel write during clearing pass");

  a_in_window: assert property (@(posedge clk) disable iff (rst)
    p1_valid |-> (p1_x <= x1c_r) && (p1_y <= y1c_r))
    else $error("pixel write outside clipped window");

  a_zero_nonread: assert property (@(posedge clk) disable iff (rst)
    !read_valid |-> ({read_red, read_green, read_blue} == '0))
    else $error("non-read result carries pixel data");
`endif

endmodule

`default_nettype wire

/* design/framebuffer_box_circle_fill.sv */
// Top level of the frame store raster block: APB registers, controller, datapath.
// Depends on fbc_pkg, fbc_cmd_if, fbc_rsp_if, fbc_cfg, fbc_ctrl, fbc_dp.
//
//   port   | dir | beat
//   -------+-----+-------------------------------------------------------
//   cmd    | in  | op, x_start, y_start, x_end, y_end, radius, red/green/blue
//   rsp    | out | read_red, read_green, read_blue, read_valid
//   apb    | in  | frame_width (0x0), frame_height (0x4)
//
// After reset the store is cleared one entry a cycle, all MAX_WIDTH*MAX_HEIGHT
// entries (16384 by default), before cmd.ready first rises.
// Read: accept, memory read, result load. Unknown op or empty window: accept,
// result load. Writes: accept, scan at one pixel per cycle on the single
// frame store write port, drain, result load; a disc scans the whole active area.
// A waiting result is held in an output register; the next command is
// accepted while it waits, and only the next result load stalls on it.
`default_nettype none

module framebuffer_box_circle_fill #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  fbc_cmd_if.sink                         cmd,
  fbc_rsp_if.source                       rsp,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [fbc_pkg::APB_AW-1:0] paddr,
  input  wire logic [fbc_pkg::APB_DW-1:0] pwdata,
  output logic      [fbc_pkg::APB_DW-1:0] prdata,
  output logic                            pready
);
  import fbc_pkg::*;

  logic [COORD_W-1:0] frame_width, frame_height;
  dp_cmd_t            dpc;
  dp_status_t         dps;
  logic               cmd_ready, rsp_valid;

  fbc_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .frame_width  (frame_width),
    .frame_height (frame_height)
  );

  fbc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd_ready),
    .cmd_op    (cmd.op),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp.ready),
    .dpc       (dpc),
    .dps       (dps)
  );

  fbc_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .dpc          (dpc),
    .dps          (dps),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .op           (cmd.op),
    .x_start      (cmd.x_start),
    .y_start      (cmd.y_start),
    .x_end        (cmd.x_end),
    .y_end        (cmd.y_end),
    .radius       (cmd.radius),
    .red          (cmd.red),
    .green        (cmd.green),
    .blue         (cmd.blue),
    .read_red     (rsp.read_red),
    .read_green   (rsp.read_green),
    .read_blue    (rsp.read_blue),
    .read_valid   (rsp.read_valid)
  );

  assign cmd.ready = cmd_ready;
  assign rsp.valid = rsp_valid;

endmodule

`default_nettype wire
